// ===== src/pvd_pkg.sv =====
`default_nettype none

package pvd_pkg;

  // value kinds, given with the first byte of a value
  localparam logic [2:0] KIND_SHORT  = 3'd0;
  localparam logic [2:0] KIND_USHORT = 3'd1;
  localparam logic [2:0] KIND_INT    = 3'd2;
  localparam logic [2:0] KIND_LONG   = 3'd3;
  localparam logic [2:0] KIND_LEN    = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_TRUNC   = 2'd2;
  localparam logic [1:0] STAT_OVER    = 2'd3;

  // payload shapes
  localparam logic [2:0] FORM_MASK13 = 3'd0;
  localparam logic [2:0] FORM_S16    = 3'd1;
  localparam logic [2:0] FORM_MASK14 = 3'd2;
  localparam logic [2:0] FORM_U16    = 3'd3;
  localparam logic [2:0] FORM_MASK28 = 3'd4;
  localparam logic [2:0] FORM_S32    = 3'd5;
  localparam logic [2:0] FORM_MASK29 = 3'd6;
  localparam logic [2:0] FORM_RAW64  = 3'd7;

  localparam int LIMIT_W = 31;

  typedef struct packed {
    logic [63:0] acc;
    logic [3:0]  left;
    logic [2:0]  kind;
    logic [2:0]  form;
    logic        neg;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] value;
    logic [1:0]  status;
  } result_t;

  function automatic logic [63:0] shape_payload(input logic [2:0] form,
                                                input logic [63:0] acc);
    logic [63:0] r;
    case (form)
      FORM_MASK13: r = {51'd0, acc[12:0]};
      FORM_S16:    r = {{48{acc[15]}}, acc[15:0]};
      FORM_MASK14: r = {50'd0, acc[13:0]};
      FORM_U16:    r = {48'd0, acc[15:0]};
      FORM_MASK28: r = {36'd0, acc[27:0]};
      FORM_S32:    r = {{32{acc[31]}}, acc[31:0]};
      FORM_MASK29: r = {35'd0, acc[28:0]};
      default:     r = acc;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/pvd_decode.sv =====
`default_nettype none

module pvd_decode (
  input  var pvd_pkg::state_t          state_i,
  input  wire logic [7:0]              data_byte_i,
  input  wire logic [2:0]              command_i,
  input  wire logic                    end_of_data_i,
  input  wire logic [pvd_pkg::LIMIT_W-1:0] len_limit_i,
  output pvd_pkg::state_t              state_o,
  output pvd_pkg::result_t             result_o
);

  always_comb begin
    pvd_pkg::state_t st;
    logic [63:0] acc_n;
    logic [3:0]  left_n;
    logic [6:0]  n;
    logic        fin;
    logic        err;
    logic        started;
    logic [1:0]  err_code;
    logic [63:0] fin_raw;
    logic [2:0]  fin_kind;
    logic        fin_neg;
    logic [63:0] v;
    logic        over;

    st       = state_i;
    n        = data_byte_i[6:0];
    fin      = 1'b0;
    err      = 1'b0;
    started  = 1'b0;
    err_code = pvd_pkg::STAT_INVALID;
    fin_raw  = '0;
    fin_kind = state_i.kind;
    fin_neg  = state_i.neg;
    acc_n    = {state_i.acc[55:0], data_byte_i};
    left_n   = state_i.left - 4'd1;

    if (state_i.left != 4'd0) begin
      st.acc  = acc_n;
      st.left = left_n;
      if (left_n == 4'd0) begin
        fin     = 1'b1;
        fin_raw = pvd_pkg::shape_payload(state_i.form, acc_n);
      end else if (end_of_data_i) begin
        err      = 1'b1;
        err_code = pvd_pkg::STAT_TRUNC;
        st.left  = 4'd0;
      end
    end else begin
      st.kind  = command_i;
      st.neg   = 1'b0;
      st.acc   = '0;
      fin_kind = command_i;
      fin_neg  = 1'b0;
      case (command_i)
        pvd_pkg::KIND_SHORT, pvd_pkg::KIND_INT, pvd_pkg::KIND_LONG: begin
          st.neg  = data_byte_i[7];
          fin_neg = data_byte_i[7];
          if (n >= 7'h40) begin
            fin     = 1'b1;
            fin_raw = {58'd0, n[5:0]};
          end else if (n >= 7'h20) begin
            started = 1'b1;
            st.form = pvd_pkg::FORM_MASK13;
            st.left = 4'd1;
            st.acc  = {56'd0, data_byte_i};
          end else if (n >= 7'h10 && command_i == pvd_pkg::KIND_SHORT) begin
            started = 1'b1;
            st.form = pvd_pkg::FORM_S16;
            st.left = 4'd2;
          end else if (n >= 7'h10) begin
            started = 1'b1;
            st.form = pvd_pkg::FORM_MASK28;
            st.left = 4'd3;
            st.acc  = {56'd0, data_byte_i};
          end else if (n >= 7'h08 && command_i != pvd_pkg::KIND_SHORT) begin
            started = 1'b1;
            st.form = pvd_pkg::FORM_S32;
            st.left = 4'd4;
          end else if (n >= 7'h04 && command_i == pvd_pkg::KIND_LONG) begin
            started = 1'b1;
            st.form = pvd_pkg::FORM_RAW64;
            st.left = 4'd8;
          end else begin
            err = 1'b1;
          end
        end
        pvd_pkg::KIND_USHORT: begin
          if (data_byte_i >= 8'h80) begin
            fin     = 1'b1;
            fin_raw = {57'd0, n};
          end else if (data_byte_i >= 8'h40) begin
            started = 1'b1;
            st.form = pvd_pkg::FORM_MASK14;
            st.left = 4'd1;
            st.acc  = {56'd0, data_byte_i};
          end else if (data_byte_i >= 8'h20) begin
            started = 1'b1;
            st.form = pvd_pkg::FORM_U16;
            st.left = 4'd2;
          end else begin
            err = 1'b1;
          end
        end
        pvd_pkg::KIND_LEN: begin
          if (data_byte_i >= 8'h80) begin
            fin     = 1'b1;
            fin_raw = {57'd0, n};
          end else if (data_byte_i >= 8'h40) begin
            started = 1'b1;
            st.form = pvd_pkg::FORM_MASK14;
            st.left = 4'd1;
            st.acc  = {56'd0, data_byte_i};
          end else if (data_byte_i >= 8'h20) begin
            started = 1'b1;
            st.form = pvd_pkg::FORM_MASK29;
            st.left = 4'd3;
            st.acc  = {56'd0, data_byte_i};
          end else if (data_byte_i >= 8'h10) begin
            started = 1'b1;
            st.form = pvd_pkg::FORM_S32;
            st.left = 4'd4;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
      if (started && end_of_data_i) begin
        err      = 1'b1;
        err_code = pvd_pkg::STAT_TRUNC;
        st.left  = 4'd0;
      end
    end

    v = fin_neg ? (64'd0 - fin_raw) : fin_raw;
    if (fin_kind == pvd_pkg::KIND_INT) begin
      v = {{32{v[31]}}, v[31:0]};
    end
    // length kinds never negate, so the raw payload is the value here
    over = (fin_kind == pvd_pkg::KIND_LEN) && (len_limit_i != '0) && !fin_raw[63] &&
           ((|fin_raw[62:pvd_pkg::LIMIT_W]) || (fin_raw[pvd_pkg::LIMIT_W-1:0] >= len_limit_i));

    state_o         = st;
    result_o.valid  = fin | err;
    result_o.value  = fin ? v : 64'd0;
    result_o.status = fin ? (over ? pvd_pkg::STAT_OVER : pvd_pkg::STAT_OK) : err_code;
  end

endmodule

`default_nettype wire

// ===== src/prefix_varint_decoder_top.sv =====
// Prefix-length varint decoder.
// Input channel: one stream word per accepted transfer (data_byte_i, command_i,
// end_of_data_i); command_i is looked at only on the first byte of a value.
// Output channel: one word (value_o, status_o) per finished, bad or truncated
// value; bytes inside a value give no output.
// Config channel: cfg_len_limit_i written when cfg_valid_i is high, ready is
// always high; write it only while no value is in flight.
// Throughput: one byte per cycle unless out_stall_i holds the result. Each byte
// passes from the input register through one decode stage into the result
// register, and the decode stage also updates the value state, so that stage
// sets the rate.
// Stall: while out_stall_i holds the result, one more byte may still be taken
// into the input register; after that in_stall_o rises until the result moves.
// Reset: clears the decoder to idle, drops any pending word, len_limit to zero.
`default_nettype none

module prefix_varint_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [2:0]  command_i,
  input  wire logic        end_of_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [63:0] value_o,
  output      logic [1:0]  status_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [pvd_pkg::LIMIT_W-1:0] cfg_len_limit_i
);

  logic                          in_valid_q;
  logic [7:0]                    in_byte_q;
  logic [2:0]                    in_cmd_q;
  logic                          in_eod_q;
  pvd_pkg::state_t               state_q, state_d;
  pvd_pkg::result_t              result_d;
  logic                          out_valid_q;
  logic [63:0]                   out_value_q;
  logic [1:0]                    out_status_q;
  logic [pvd_pkg::LIMIT_W-1:0]   len_limit_q;
  logic                          advance;
  logic                          process;

  assign advance     = !out_valid_q || !out_stall_i;
  assign process     = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign cfg_ready_o = 1'b1;

  pvd_decode u_decode (
    .state_i       (state_q),
    .data_byte_i   (in_byte_q),
    .command_i     (in_cmd_q),
    .end_of_data_i (in_eod_q),
    .len_limit_i   (len_limit_q),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
      len_limit_q <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (process) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= process && result_d.valid;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        len_limit_q <= cfg_len_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= data_byte_i;
      in_cmd_q  <= command_i;
      in_eod_q  <= end_of_data_i;
    end
    if (process && result_d.valid) begin
      out_value_q  <= result_d.value;
      out_status_q <= result_d.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign status_o    = out_status_q;

  // input side only holds off when a word is parked in the input register
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  // bad and truncated values carry zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == pvd_pkg::STAT_INVALID || status_o == pvd_pkg::STAT_TRUNC)
    |-> value_o == 64'd0)
    else $error("error result with nonzero value");

  // over-limit flag only with the check enabled
  a_over_needs_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pvd_pkg::STAT_OVER |-> len_limit_q != '0)
    else $error("length flagged with limit disabled");

  // at most eight payload bytes outstanding
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.left <= 4'd8)
    else $error("byte count out of range");

endmodule

`default_nettype wire
